/* rtl/core/page_table_builder_assert.svh */
// assertion macros for the page table builder
// used by the top level; needs clk and arst_n in the including scope
`ifndef PAGE_TABLE_BUILDER_ASSERT_SVH
`define PAGE_TABLE_BUILDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PTB_NEVER(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) else $error(msg);
`else
`define PTB_ASSERT(lbl, prop, msg)
`define PTB_NEVER(lbl, prop, msg)
`endif
`endif

/* rtl/core/ptb_pkg.sv */
// shared types, constants and descriptor encoders of the page table builder
// no dependencies
`default_nettype none
package ptb_pkg;
	localparam int POOL_TABLES = 8;
	localparam int SLOT_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
	localparam int L1_DEPTH = 4096;
	localparam int L2_DEPTH = POOL_TABLES * 256;
	localparam int L2_AW = SLOT_W + 8;
	localparam int SWEEP_N = (L2_DEPTH > L1_DEPTH) ? L2_DEPTH : L1_DEPTH;
	localparam int SWEEP_W = $clog2(SWEEP_N);

	localparam logic [31:0] TABLE_MASK = 32'hfffffc00;
	localparam logic [31:0] SECTION_MASK = 32'hfff00000;
	localparam logic [31:0] PAGE_MASK = 32'hfffff000;

	localparam logic [2:0] REQ_CLEAR = 3'd0;
	localparam logic [2:0] REQ_SECTION = 3'd1;
	localparam logic [2:0] REQ_PREPARE = 3'd2;
	localparam logic [2:0] REQ_PAGE = 3'd3;
	localparam logic [2:0] REQ_READ1 = 3'd4;
	localparam logic [2:0] REQ_READ2 = 3'd5;

	localparam logic [2:0] MT_NORMAL_X = 3'd1;
	localparam logic [2:0] MT_NORMAL_XN = 3'd2;
	localparam logic [2:0] MT_NOACC_XN = 3'd3;
	localparam logic [2:0] MT_DEVICE = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_TABLE = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;

	localparam logic [1:0] L1_FAULT = 2'b00;
	localparam logic [1:0] L1_TABLE = 2'b01;

	typedef struct packed {
		logic [2:0] req_type;
		logic [31:0] virt_addr;
		logic [31:0] phys_addr;
		logic [2:0] mem_type;
		logic [3:0] domain_id;
	} in_item_t;

	typedef struct packed {
		logic [31:0] descriptor;
		logic [31:0] descriptor_addr;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic [2:0] req;
		logic [11:0] i1;
		logic [7:0] i2;
		logic [3:0] dom;
		logic [31:0] sec_desc;
		logic [31:0] page_desc;
	} work_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} back_stat_t;

	function automatic logic [31:0] section_desc(logic [31:0] pa, logic [2:0] mt,
			logic [3:0] dom);
		logic [31:0] b;
		logic [31:0] r;
		b = (pa & SECTION_MASK) | {23'd0, dom, 5'd0} | 32'h2 | (32'h1 << 16);
		unique case (mt)
			MT_NORMAL_X: r = b | (32'h1 << 12) | (32'h3 << 10) | 32'hc;
			MT_NORMAL_XN: r = b | (32'h1 << 12) | (32'h3 << 10) | 32'h1c;
			MT_NOACC_XN: r = b | (32'h1 << 12) | 32'h1c;
			MT_DEVICE: r = b | (32'h3 << 10) | 32'h14;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] page_desc(logic [31:0] pa, logic [2:0] mt);
		logic [31:0] b;
		logic [31:0] r;
		b = (pa & PAGE_MASK) | 32'h2 | (32'h1 << 10);
		unique case (mt)
			MT_NORMAL_X: r = b | (32'h1 << 6) | (32'h3 << 4) | 32'hc;
			MT_NORMAL_XN: r = b | (32'h1 << 6) | (32'h3 << 4) | 32'hd;
			MT_NOACC_XN: r = b | (32'h1 << 6) | 32'hd;
			MT_DEVICE: r = b | (32'h3 << 4) | 32'h5;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/core/ptb_front.sv */
// front end: accepts request words, decodes indexes and encodes descriptors
// into a two-entry work queue; uses ptb_pkg
`default_nettype none
module ptb_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire ptb_pkg::in_item_t item,
	output logic work_valid,
	input wire logic work_pop,
	output ptb_pkg::work_t work
);
	import ptb_pkg::*;

	work_t q_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	work_t cls;
	logic do_push, do_pop;

	always_comb begin
		cls.req = item.req_type;
		cls.i1 = item.virt_addr[31:20];
		cls.i2 = item.virt_addr[19:12];
		cls.dom = item.domain_id;
		cls.sec_desc = section_desc(item.phys_addr, item.mem_type, item.domain_id);
		cls.page_desc = page_desc(item.phys_addr, item.mem_type);
	end

	assign full = (cnt_q == 2'd2);
	assign work_valid = (cnt_q != 2'd0);
	assign work = q_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = work_pop && work_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

/* rtl/core/ptb_back.sv */
// back end: table memories, pool slot bookkeeping, request sequencer and
// result register; uses ptb_pkg
`default_nettype none
module ptb_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [31:0] l1_base,
	input wire logic [31:0] l2_base,
	input wire logic work_valid,
	output logic work_pop,
	input wire ptb_pkg::work_t work,
	output logic empty,
	input wire logic pop,
	output ptb_pkg::result_t result,
	output ptb_pkg::back_stat_t stat
);
	import ptb_pkg::*;

	typedef enum logic [1:0] {S_CLR, S_IDLE, S_RD1, S_RD2} state_t;

	state_t state_q;
	logic [SWEEP_W-1:0] cnt_q;
	work_t work_q;
	logic out_valid_q;
	result_t out_q;
	logic slot_used_q [POOL_TABLES];
	logic [11:0] slot_owner_q [POOL_TABLES];

	logic [31:0] l1_mem [L1_DEPTH];
	logic [31:0] l2_mem [L2_DEPTH];
	logic [31:0] l1_rd_q, l2_rd_q;

	logic l1_we, l2_we;
	logic [11:0] l1_wa;
	logic [31:0] l1_wd, l2_wd;
	logic [L2_AW-1:0] l2_wa, l2_ra;

	logic own_hit, free_hit;
	logic [SLOT_W-1:0] own_idx, free_idx, sel_s;
	logic tab_ok, alloc;
	logic [1:0] tab_st;
	logic [31:0] new_l1, slot_base;
	logic [31:0] l1_addr;
	logic sweep_l1, sweep_l2, sweep_end;

	assign work_pop = (state_q == S_IDLE) && work_valid && !out_valid_q;
	assign empty = !out_valid_q;
	assign result = out_q;
	assign stat.clearing = (state_q == S_CLR);
	assign stat.busy = (state_q == S_RD1) || (state_q == S_RD2);

	assign l1_addr = {l1_base[31:14], work_q.i1, 2'b00};
	assign sweep_l1 = ({1'b0, cnt_q} < (SWEEP_W + 1)'(L1_DEPTH));
	assign sweep_l2 = ({1'b0, cnt_q} < (SWEEP_W + 1)'(L2_DEPTH));
	assign sweep_end = (cnt_q == SWEEP_W'(SWEEP_N - 1));

	// slot lookup: owner match and lowest free slot
	always_comb begin
		own_hit = 1'b0;
		own_idx = '0;
		free_hit = 1'b0;
		free_idx = '0;
		for (int s = POOL_TABLES - 1; s >= 0; s--) begin
			if (slot_used_q[s] && slot_owner_q[s] == work_q.i1) begin
				own_hit = 1'b1;
				own_idx = SLOT_W'(s);
			end
			if (!slot_used_q[s]) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(s);
			end
		end
	end

	// first-level entry classification for table requests
	always_comb begin
		tab_ok = 1'b0;
		alloc = 1'b0;
		tab_st = ST_NOT_TABLE;
		sel_s = own_idx;
		priority if (l1_rd_q[1:0] == L1_TABLE) begin
			tab_ok = own_hit;
			tab_st = own_hit ? ST_OK : ST_NOT_TABLE;
		end else if (l1_rd_q[1:0] == L1_FAULT) begin
			if (own_hit) begin
				tab_ok = 1'b1;
				tab_st = ST_OK;
			end else if (free_hit) begin
				tab_ok = 1'b1;
				alloc = 1'b1;
				tab_st = ST_OK;
				sel_s = free_idx;
			end else begin
				tab_st = ST_POOL_FULL;
			end
		end else begin
			tab_st = ST_NOT_TABLE;
		end
		slot_base = (l2_base & TABLE_MASK) + (32'(sel_s) << 10);
		if (l1_rd_q[1:0] == L1_TABLE) begin
			new_l1 = l1_rd_q;
		end else begin
			new_l1 = (slot_base & TABLE_MASK) | {23'd0, work_q.dom, 5'd0} | 32'h1;
		end
	end

	always_comb begin
		l1_we = 1'b0;
		l1_wa = work_q.i1;
		l1_wd = 32'd0;
		l2_we = 1'b0;
		l2_wa = {sel_s, work_q.i2};
		l2_wd = work_q.page_desc;
		l2_ra = {own_idx, work_q.i2};
		unique case (state_q)
			S_CLR: begin
				l1_we = sweep_l1;
				l1_wa = cnt_q[11:0];
				l2_we = sweep_l2;
				l2_wa = cnt_q[L2_AW-1:0];
				l2_wd = 32'd0;
			end
			S_RD1: begin
				if (work_q.req == REQ_SECTION) begin
					l1_we = 1'b1;
					l1_wd = work_q.sec_desc;
				end else if (work_q.req == REQ_PREPARE || work_q.req == REQ_PAGE) begin
					l1_we = tab_ok && (l1_rd_q[1:0] == L1_FAULT);
					l1_wd = new_l1;
					l2_we = tab_ok && (work_q.req == REQ_PAGE);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (l1_we) l1_mem[l1_wa] <= l1_wd;
		if (work_pop) l1_rd_q <= l1_mem[work.i1];
	end

	always_ff @(posedge clk) begin
		if (l2_we) l2_mem[l2_wa] <= l2_wd;
		if (state_q == S_RD1) l2_rd_q <= l2_mem[l2_ra];
	end

	always_ff @(posedge clk) begin
		if (work_pop) work_q <= work;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			for (int s = 0; s < POOL_TABLES; s++) begin
				slot_used_q[s] <= 1'b0;
				slot_owner_q[s] <= '0;
			end
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (sweep_end) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (work_pop) state_q <= S_RD1;
				end
				S_RD1: begin
					out_q <= '0;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
					unique case (work_q.req)
						REQ_CLEAR: begin
							cnt_q <= '0;
							state_q <= S_CLR;
							for (int s = 0; s < POOL_TABLES; s++) begin
								slot_used_q[s] <= 1'b0;
								slot_owner_q[s] <= '0;
							end
						end
						REQ_SECTION: begin
							out_q.descriptor <= work_q.sec_desc;
							out_q.descriptor_addr <= l1_addr;
						end
						REQ_PREPARE, REQ_PAGE: begin
							out_q.status <= tab_st;
							if (tab_ok) begin
								if (alloc) begin
									slot_used_q[sel_s] <= 1'b1;
									slot_owner_q[sel_s] <= work_q.i1;
								end
								if (work_q.req == REQ_PREPARE) begin
									out_q.descriptor <= new_l1;
									out_q.descriptor_addr <= l1_addr;
								end else begin
									out_q.descriptor <= work_q.page_desc;
									// table base has its low ten bits clear
									out_q.descriptor_addr <= (new_l1 & TABLE_MASK)
										| {22'd0, work_q.i2, 2'b00};
								end
							end
						end
						REQ_READ1: begin
							out_q.descriptor <= l1_rd_q;
							out_q.descriptor_addr <= l1_addr;
						end
						REQ_READ2: begin
							if ((l1_rd_q[1:0] == L1_TABLE) && own_hit) begin
								out_valid_q <= 1'b0;
								state_q <= S_RD2;
							end else begin
								out_q.status <= ST_NOT_TABLE;
							end
						end
						default: begin
						end
					endcase
				end
				S_RD2: begin
					out_q.descriptor <= l2_rd_q;
					out_q.descriptor_addr <= (l1_rd_q & TABLE_MASK)
						| {22'd0, work_q.i2, 2'b00};
					out_q.status <= ST_OK;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/core/page_table_builder.sv */
// page table builder top level: configuration registers, front and back end
// uses ptb_pkg, ptb_front, ptb_back and page_table_builder_assert.svh
//
// requests enter through a queue-style port: a word is taken when push is
// high and full is low; up to two words wait in the front queue while the
// back end works. results leave the same way: the oldest result sits on
// result while empty is low and is taken when pop is high.
// after a request leaves the queue the back end holds its first-level
// entry in a register, works the request in S_RD1 and, for a second-level
// read, returns the registered second-level memory read from S_RD2. it
// starts a new word only from idle and while no result waits to be popped.
// a clear request returns its result at once, then sweeps both table
// memories one entry a cycle; no request is started during the sweep. the
// same sweep runs after reset, so words pushed then only wait in the queue.
// when the receiver does not pop, the back end holds its single result and
// the front queue fills, then full rises.
// l1_table_base sits at address 0 and l2_pool_base at address 4.
`default_nettype none
module page_table_builder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic push,
	output logic full,
	input wire ptb_pkg::in_item_t item,
	output logic empty,
	input wire logic pop,
	output ptb_pkg::result_t result
);
	import ptb_pkg::*;

	logic [31:0] l1_base_q, l2_base_q;
	logic work_valid, work_pop;
	work_t work;
	back_stat_t stat;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? l2_base_q : l1_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_base_q <= 32'd0;
			l2_base_q <= 32'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) l2_base_q <= pwdata;
			else l1_base_q <= pwdata;
		end
	end

	ptb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.work_valid(work_valid),
		.work_pop(work_pop),
		.work(work)
	);

	ptb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.l1_base(l1_base_q),
		.l2_base(l2_base_q),
		.work_valid(work_valid),
		.work_pop(work_pop),
		.work(work),
		.empty(empty),
		.pop(pop),
		.result(result),
		.stat(stat)
	);

`include "page_table_builder_assert.svh"

	`PTB_NEVER(a_no_start_in_sweep, stat.clearing && work_pop, "word started during sweep")
	`PTB_ASSERT(a_refuse_zero, (!empty && result.status != ST_OK) |-> (result.descriptor == 32'd0 && result.descriptor_addr == 32'd0), "refused word not zero")
	`PTB_NEVER(a_busy_pop, stat.busy && work_pop, "second word started while busy")
endmodule
`default_nettype wire
